// ===== hdl/kgsr_pkg.sv =====
// Shared constants and types for the k-group stream reverser.
package kgsr_pkg;

    localparam int MAX_GROUP_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // group size register
    localparam int          CFG_W          = 5;
    localparam logic [4:0]  GROUP_SIZE_RST = 5'd2;

    // bank release from the drain side back to the collect side
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

// ===== hdl/kgsr_if.sv =====
// Stream interfaces for the input requests and the reordered results.
interface kgsr_in_if #(
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         end_of_sequence;

    modport source (output valid, output value, output end_of_sequence, input ready);
    modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface kgsr_out_if #(
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// ===== hdl/kgsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kgsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kgsr_front.sv =====
// Collect side: takes requests, writes them into the current bank, issues drain commands.
module kgsr_front #(
    parameter int  MAX_GROUP  = kgsr_pkg::MAX_GROUP_DEF,
    parameter int  DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF,
    parameter int  CNT_W      = $clog2(MAX_GROUP + 1),
    parameter int  AW         = $clog2(2 * MAX_GROUP),
    parameter type t_cmd      = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kgsr_pkg::CFG_W-1:0]    i_cfg_data,
    kgsr_in_if.sink                       i_in,
    input  kgsr_pkg::t_rel                i_rel,
    input  logic                          i_q_full,
    output logic                          o_push,
    output t_cmd                          o_cmd,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [DATA_WIDTH-1:0]         o_wdata
);
    import kgsr_pkg::*;

    logic [CFG_W-1:0] r_group_size;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;
    logic [CNT_W-1:0] k_eff;
    logic [CNT_W-1:0] cnt;
    logic             take;
    logic             full_grp;
    logic             flush;

    always_comb begin
        if (r_group_size == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(r_group_size) > MAX_GROUP) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = CNT_W'(r_group_size);
        end
    end

    assign i_in.ready = !r_busy[r_bank] && !i_q_full;
    assign take       = i_in.valid && i_in.ready;
    assign cnt        = r_fill + CNT_W'(1);
    assign full_grp   = cnt >= k_eff;
    assign flush      = full_grp || i_in.end_of_sequence;

    assign o_we    = take;
    assign o_waddr = AW'(r_bank ? MAX_GROUP : 0) + AW'(r_fill);
    assign o_wdata = DATA_WIDTH'(i_in.value);

    assign o_push      = take && flush;
    assign o_cmd.bank  = r_bank;
    assign o_cmd.count = cnt;
    assign o_cmd.rev   = full_grp;
    assign o_cmd.last  = i_in.end_of_sequence;

    always_comb begin
        n_fill = r_fill;
        n_bank = r_bank;
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (take) begin
            if (flush) begin
                n_fill         = '0;
                n_bank         = !r_bank;
                n_busy[r_bank] = 1'b1;
            end else begin
                n_fill = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_SIZE_RST;
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_busy       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_group_size <= i_cfg_data;
            end
            r_fill <= n_fill;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

endmodule

// ===== hdl/kgsr_cmd_q.sv =====
// Two-entry command queue between the collect and drain sides.
module kgsr_cmd_q #(
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== hdl/kgsr_back.sv =====
// Drain side: walks one bank per command and presents results on the output stream.
module kgsr_back #(
    parameter int  MAX_GROUP  = kgsr_pkg::MAX_GROUP_DEF,
    parameter int  DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF,
    parameter int  CNT_W      = $clog2(MAX_GROUP + 1),
    parameter int  AW         = $clog2(2 * MAX_GROUP),
    parameter type t_cmd      = logic
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output kgsr_pkg::t_rel        o_rel,
    output logic                  o_re,
    output logic [AW-1:0]         o_raddr,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    kgsr_out_if.source            o_out
);
    import kgsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_rd_pend;
    logic                    r_rd_last;
    logic                    r_out_v;
    logic [DATA_WIDTH-1:0]   r_out_value;
    logic                    r_out_last;
    logic                    issue;
    logic                    last_issue;
    logic [CNT_W-1:0]        pos;

    // one read in flight at a time, launched only when the output slot frees up
    assign issue      = (r_state == S_RUN) && !r_rd_pend && (!r_out_v || o_out.ready);
    assign last_issue = issue && (r_idx == r_cmd.count - CNT_W'(1));
    assign pos        = r_cmd.rev ? (r_cmd.count - CNT_W'(1) - r_idx) : r_idx;

    assign o_re      = issue;
    assign o_raddr   = AW'(r_cmd.bank ? MAX_GROUP : 0) + AW'(pos);
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_rel.valid = last_issue;
    assign o_rel.bank  = r_cmd.bank;

    assign o_out.valid     = r_out_v;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_rd_last <= r_cmd.last && last_issue;
        end
        if (r_rd_pend) begin
            r_out_value <= i_rdata;
            r_out_last  <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            if (r_rd_pend) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_idx   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (last_issue) begin
                        r_state <= S_IDLE;
                    end else if (issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/k_group_stream_reverser.sv =====
// Top level of the k-group stream reverser.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+-----------------------------------
//  i_in       | in  | valid / ready      | value, end_of_sequence
//  o_out      | out | valid / ready      | out_value, out_last
//  i_cfg_*    | in  | write enable only  | group_size (5 bits)
//
// Each result passes through the RAM read register, then the output register;
// a new read is launched only after the previous result reaches the output.
// Two RAM banks alternate: a new group collects while the previous one drains;
// collection stalls only while both banks hold groups not yet fully drained.
// Reset (synchronous, active low) empties both banks and the command queue; no
// clearing pass is needed. group_size resets to 2.
module k_group_stream_reverser #(
    parameter int MAX_GROUP  = kgsr_pkg::MAX_GROUP_DEF,
    parameter int DATA_WIDTH = kgsr_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [kgsr_pkg::CFG_W-1:0] i_cfg_data,
    kgsr_in_if.sink                    i_in,
    kgsr_out_if.source                 o_out
);
    import kgsr_pkg::*;

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int AW    = $clog2(2 * MAX_GROUP);

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } t_cmd;

    t_cmd                  push_cmd;
    t_cmd                  head_cmd;
    t_rel                  rel;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    kgsr_front #(
        .MAX_GROUP (MAX_GROUP),
        .DATA_WIDTH(DATA_WIDTH),
        .CNT_W     (CNT_W),
        .AW        (AW),
        .t_cmd     (t_cmd)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (i_in),
        .i_rel     (rel),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    kgsr_cmd_q #(
        .t_cmd(t_cmd)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    kgsr_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(2 * MAX_GROUP),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    kgsr_back #(
        .MAX_GROUP (MAX_GROUP),
        .DATA_WIDTH(DATA_WIDTH),
        .CNT_W     (CNT_W),
        .AW        (AW),
        .t_cmd     (t_cmd)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_empty(q_empty),
        .o_pop    (pop),
        .o_rel    (rel),
        .o_re     (re),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_out    (o_out)
    );

    // a command is never dropped on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");

    // the RAM is never read and written at the same address in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("bank written while being drained");

    // a bank is released only in a cycle that issues a read from it
    a_rel_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rel.valid |-> re)
        else $error("bank released without a read");

    // after reset no result is offered
    a_out_idle_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
